/* rtl/kcg_pkg.sv */
package kcg_pkg;

  localparam int MAX_ALPHABET = 64;
  localparam int MAX_LENGTH   = 16;

  localparam int SYM_W   = 8;
  localparam int IDX_W   = 64;
  localparam int SLOT_W  = $clog2(MAX_ALPHABET);
  localparam int RADIX_W = $clog2(MAX_ALPHABET) + 1;
  localparam int LEN_W   = 5;
  localparam int POS_W   = 4;
  localparam int ACT_W   = 2;
  localparam int CFG_W   = 7;

  // Restoring division of the index by the radix, several quotient bits per cycle
  localparam int DIV_STEPS  = 8;
  localparam int DIV_CYCLES = IDX_W / DIV_STEPS;
  localparam int DCNT_W     = $clog2(DIV_CYCLES);

  typedef logic [ACT_W-1:0] action_t;
  localparam action_t ACT_LOAD  = 2'd0;
  localparam action_t ACT_START = 2'd1;
  localparam action_t ACT_STEP  = 2'd2;

  localparam logic CFG_ALPHABET_SIZE    = 1'b0;
  localparam logic CFG_CANDIDATE_LENGTH = 1'b1;

  typedef struct packed {
    logic load_sym;
    logic start_rng;
    logic step_init;
    logic div_run;
    logic ram_rd;
    logic emit_char;
    logic emit_exh;
  } kcg_cmd_t;

  typedef struct packed {
    logic exhausted;
    logic div_done;
    logic last_digit;
    logic out_free;
  } kcg_sts_t;

endpackage

/* rtl/kcg_ram.sv */
module kcg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/kcg_ctrl.sv */
module kcg_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  kcg_pkg::action_t     action_i,
  input  kcg_pkg::kcg_sts_t    sts_i,
  output logic                 in_stall_o,
  output kcg_pkg::kcg_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_RD,
    ST_EMIT,
    ST_EXH
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (action_i)
            kcg_pkg::ACT_LOAD:  cmd_o.load_sym  = 1'b1;
            kcg_pkg::ACT_START: cmd_o.start_rng = 1'b1;
            kcg_pkg::ACT_STEP: begin
              if (sts_i.exhausted) begin
                state_d = ST_EXH;
              end else begin
                cmd_o.step_init = 1'b1;
                state_d         = ST_DIV;
              end
            end
            default: ;
          endcase
        end
      end
      ST_DIV: begin
        cmd_o.div_run = 1'b1;
        if (sts_i.div_done) begin
          state_d = ST_RD;
        end
      end
      ST_RD: begin
        cmd_o.ram_rd = 1'b1;
        state_d      = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_char = 1'b1;
          state_d         = sts_i.last_digit ? ST_IDLE : ST_DIV;
        end
      end
      ST_EXH: begin
        if (sts_i.out_free) begin
          cmd_o.emit_exh = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

/* rtl/kcg_dp.sv */
module kcg_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  kcg_pkg::kcg_cmd_t                  cmd_i,
  output kcg_pkg::kcg_sts_t                  sts_o,
  input  logic                               cfg_we_i,
  input  logic                               cfg_idx_i,
  input  logic [kcg_pkg::CFG_W-1:0]          cfg_data_i,
  input  logic [kcg_pkg::SLOT_W-1:0]         symbol_slot_i,
  input  logic [kcg_pkg::SYM_W-1:0]          symbol_value_i,
  input  logic [kcg_pkg::IDX_W-1:0]          range_first_i,
  input  logic [kcg_pkg::IDX_W-1:0]          range_stop_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [kcg_pkg::SYM_W-1:0]          char_out_o,
  output logic [kcg_pkg::POS_W-1:0]          char_position_o,
  output logic                               last_char_o,
  output logic                               exhausted_o,
  output logic [kcg_pkg::IDX_W-1:0]          candidate_index_o
);

  logic [kcg_pkg::RADIX_W-1:0] asize_q;
  logic [kcg_pkg::LEN_W-1:0]   clen_q;
  logic [kcg_pkg::RADIX_W-1:0] radix;
  logic [kcg_pkg::LEN_W-1:0]   len;

  logic [kcg_pkg::IDX_W-1:0]   idx_q, end_q;
  logic [kcg_pkg::IDX_W-1:0]   num_q, num_d;
  logic [kcg_pkg::RADIX_W-1:0] rem_q, rem_d;
  logic [kcg_pkg::DCNT_W-1:0]  cnt_q;
  logic [kcg_pkg::POS_W-1:0]   dig_q;
  logic [kcg_pkg::LEN_W-1:0]   len_m1;
  logic                        last_digit;
  logic [kcg_pkg::SYM_W-1:0]   ram_rdata;

  logic                        out_valid_q;
  logic [kcg_pkg::SYM_W-1:0]   char_q;
  logic [kcg_pkg::POS_W-1:0]   pos_q;
  logic                        last_q;
  logic                        exh_q;
  logic [kcg_pkg::IDX_W-1:0]   cidx_q;
  logic                        out_free;

  // Clamp the configuration into the supported range
  always_comb begin
    if (asize_q == '0) begin
      radix = kcg_pkg::RADIX_W'(1);
    end else if (asize_q > kcg_pkg::RADIX_W'(kcg_pkg::MAX_ALPHABET)) begin
      radix = kcg_pkg::RADIX_W'(kcg_pkg::MAX_ALPHABET);
    end else begin
      radix = asize_q;
    end
    if (clen_q == '0) begin
      len = kcg_pkg::LEN_W'(1);
    end else if (clen_q > kcg_pkg::LEN_W'(kcg_pkg::MAX_LENGTH)) begin
      len = kcg_pkg::LEN_W'(kcg_pkg::MAX_LENGTH);
    end else begin
      len = clen_q;
    end
  end

  assign len_m1     = len - kcg_pkg::LEN_W'(1);
  assign last_digit = ({1'b0, dig_q} == len_m1);

  // DIV_STEPS restoring steps per cycle; remainder stays below the radix
  always_comb begin
    logic [kcg_pkg::RADIX_W-1:0] t;
    logic [kcg_pkg::RADIX_W-1:0] r;
    logic [kcg_pkg::IDX_W-1:0]   n;
    r = rem_q;
    n = num_q;
    for (int i = 0; i < kcg_pkg::DIV_STEPS; i++) begin
      t = {r[kcg_pkg::RADIX_W-2:0], n[kcg_pkg::IDX_W-1]};
      if (t >= radix) begin
        r = t - radix;
        n = {n[kcg_pkg::IDX_W-2:0], 1'b1};
      end else begin
        r = t;
        n = {n[kcg_pkg::IDX_W-2:0], 1'b0};
      end
    end
    rem_d = r;
    num_d = n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      asize_q <= kcg_pkg::RADIX_W'(1);
      clen_q  <= kcg_pkg::LEN_W'(1);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == kcg_pkg::CFG_ALPHABET_SIZE) begin
        asize_q <= cfg_data_i[kcg_pkg::RADIX_W-1:0];
      end else begin
        clen_q <= cfg_data_i[kcg_pkg::LEN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      end_q <= '0;
    end else if (cmd_i.start_rng) begin
      idx_q <= range_first_i;
      end_q <= range_stop_i;
    end else if (cmd_i.emit_char && last_digit) begin
      idx_q <= idx_q + kcg_pkg::IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      dig_q <= '0;
    end else if (cmd_i.step_init) begin
      cnt_q <= '0;
      dig_q <= '0;
    end else if (cmd_i.div_run) begin
      cnt_q <= cnt_q + kcg_pkg::DCNT_W'(1);
    end else if (cmd_i.emit_char) begin
      cnt_q <= '0;
      dig_q <= dig_q + kcg_pkg::POS_W'(1);
    end
  end

  // Quotient stays in num_q and feeds the next digit
  always_ff @(posedge clk_i) begin
    if (cmd_i.step_init) begin
      num_q <= idx_q;
      rem_q <= '0;
    end else if (cmd_i.div_run) begin
      num_q <= num_d;
      rem_q <= rem_d;
    end else if (cmd_i.emit_char) begin
      rem_q <= '0;
    end
  end

  kcg_ram #(
    .WIDTH(kcg_pkg::SYM_W),
    .DEPTH(kcg_pkg::MAX_ALPHABET)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (cmd_i.load_sym),
    .waddr_i(symbol_slot_i),
    .wdata_i(symbol_value_i),
    .re_i   (cmd_i.ram_rd),
    .raddr_i(rem_q[kcg_pkg::SLOT_W-1:0]),
    .rdata_o(ram_rdata)
  );

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_char || cmd_i.emit_exh) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_char) begin
      char_q <= ram_rdata;
      pos_q  <= kcg_pkg::POS_W'(len_m1 - {1'b0, dig_q});
      last_q <= last_digit;
      exh_q  <= 1'b0;
      cidx_q <= idx_q;
    end else if (cmd_i.emit_exh) begin
      char_q <= '0;
      pos_q  <= '0;
      last_q <= 1'b0;
      exh_q  <= 1'b1;
      cidx_q <= idx_q;
    end
  end

  assign sts_o.exhausted  = (idx_q >= end_q);
  assign sts_o.div_done   = (cnt_q == kcg_pkg::DCNT_W'(kcg_pkg::DIV_CYCLES - 1));
  assign sts_o.last_digit = last_digit;
  assign sts_o.out_free   = out_free;

  assign out_valid_o       = out_valid_q;
  assign char_out_o        = char_q;
  assign char_position_o   = pos_q;
  assign last_char_o       = last_q;
  assign exhausted_o       = exh_q;
  assign candidate_index_o = cidx_q;

endmodule

/* rtl/keyspace_candidate_generator.sv */
// Password candidate enumerator over a loaded alphabet.
// Input channel (in_valid_i / in_stall_o): one item per handshake. A load item
// writes symbol_value_i into slot symbol_slot_i, a start item sets the current
// index and the exclusive range end, a step item emits the next candidate.
// Output channel (out_valid_o / out_stall_i): one character per item, least
// significant digit first, last_char_o on the final one; a step at or past
// the range end gives a single item with exhausted_o set.
// Load and start are taken while idle and do not stall the input. A step
// divides the 64-bit index by the radix for each digit, 8 quotient bits per
// cycle, then reads the alphabet table and writes the character into the
// output register. Configuration (cfg_we_i, cfg_idx_i, cfg_data_i) must be
// written only while idle; the block itself does not enforce it.
// Reset clears index and range end and sets alphabet size and length to 1;
// the alphabet table holds garbage until loaded.
// A stalled receiver holds the output register; the block waits for it before
// writing the next character and stalls the input until the step is done.
module keyspace_candidate_generator (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic                               cfg_idx_i,
  input  logic [kcg_pkg::CFG_W-1:0]          cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [kcg_pkg::ACT_W-1:0]          action_i,
  input  logic [kcg_pkg::SLOT_W-1:0]         symbol_slot_i,
  input  logic [kcg_pkg::SYM_W-1:0]          symbol_value_i,
  input  logic [kcg_pkg::IDX_W-1:0]          range_first_i,
  input  logic [kcg_pkg::IDX_W-1:0]          range_stop_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [kcg_pkg::SYM_W-1:0]          char_out_o,
  output logic [kcg_pkg::POS_W-1:0]          char_position_o,
  output logic                               last_char_o,
  output logic                               exhausted_o,
  output logic [kcg_pkg::IDX_W-1:0]          candidate_index_o
);

  kcg_pkg::kcg_cmd_t cmd;
  kcg_pkg::kcg_sts_t sts;

  kcg_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .action_i  (action_i),
    .sts_i     (sts),
    .in_stall_o(in_stall_o),
    .cmd_o     (cmd)
  );

  kcg_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .symbol_slot_i    (symbol_slot_i),
    .symbol_value_i   (symbol_value_i),
    .range_first_i    (range_first_i),
    .range_stop_i     (range_stop_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .char_out_o       (char_out_o),
    .char_position_o  (char_position_o),
    .last_char_o      (last_char_o),
    .exhausted_o      (exhausted_o),
    .candidate_index_o(candidate_index_o)
  );

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import kcg_pkg::*;

  localparam action_t ACT_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam int ITEM_TARGET = 330;
  localparam int PRINT_CAP = 30;
  localparam logic [IDX_W-1:0] IDX_MAX = '1;

  typedef struct packed {
    logic [SYM_W-1:0] ch;
    logic [POS_W-1:0] pos;
    logic             last;
    logic             exh;
    logic [IDX_W-1:0] idx;
  } char_result_t;

  typedef struct {
    logic             is_cfg;
    logic             cfg_sel;
    logic [CFG_W-1:0] cfg_val;
    action_t          act;
    logic [SLOT_W-1:0] slot;
    logic [SYM_W-1:0] sym;
    logic [IDX_W-1:0] first;
    logic [IDX_W-1:0] stop;
    logic             typed;
    char_result_t     res;
  } plan_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic              cfg_idx_i = 1'b0;
  logic [CFG_W-1:0]  cfg_data_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [ACT_W-1:0]  action_i = '0;
  logic [SLOT_W-1:0] symbol_slot_i = '0;
  logic [SYM_W-1:0]  symbol_value_i = '0;
  logic [IDX_W-1:0]  range_first_i = '0;
  logic [IDX_W-1:0]  range_stop_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [SYM_W-1:0]  char_out_o;
  logic [POS_W-1:0]  char_position_o;
  logic              last_char_o;
  logic              exhausted_o;
  logic [IDX_W-1:0]  candidate_index_o;

  always #5 clk_i = ~clk_i;

  keyspace_candidate_generator dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .action_i          (action_i),
    .symbol_slot_i     (symbol_slot_i),
    .symbol_value_i    (symbol_value_i),
    .range_first_i     (range_first_i),
    .range_stop_i      (range_stop_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .char_out_o        (char_out_o),
    .char_position_o   (char_position_o),
    .last_char_o       (last_char_o),
    .exhausted_o       (exhausted_o),
    .candidate_index_o (candidate_index_o)
  );

  // enumerator state as seen from outside
  logic [SYM_W-1:0] sym_tbl [MAX_ALPHABET];
  logic [IDX_W-1:0] cur_idx = '0;
  logic [IDX_W-1:0] stop_idx = '0;
  logic [CFG_W-1:0] alpha_reg = 7'd1;
  logic [LEN_W-1:0] len_reg = 5'd1;
  char_result_t     cand_buf [MAX_LENGTH];
  char_result_t     due_chars [$];

  int err_count = 0;
  int items_in = 0;
  int n_steps = 0;
  int n_exh = 0;
  int n_chars = 0;
  int n_writes = 0;
  int quiet_cycles = 0;
  int tx_mode_left = 0;
  bit tx_calm = 1'b0;
  int rx_mode_left = 0;
  bit rx_calm = 1'b0;
  int stall_left = 0;
  int hold_left = 0;
  bit pressure_done = 1'b0;

  function automatic int enumerate_item(action_t a, logic [SLOT_W-1:0] s,
                                        logic [SYM_W-1:0] v, logic [IDX_W-1:0] f,
                                        logic [IDX_W-1:0] e);
    logic [IDX_W-1:0] radix;
    logic [IDX_W-1:0] rest;
    int clen;
    int k;
    radix = (alpha_reg == 0) ? 64'd1 :
            (alpha_reg > MAX_ALPHABET) ? 64'(MAX_ALPHABET) : 64'(alpha_reg);
    clen = (len_reg == 0) ? 1 : (len_reg > MAX_LENGTH) ? MAX_LENGTH : int'(len_reg);
    case (a)
      ACT_LOAD: sym_tbl[s] = v;
      ACT_START: begin
        cur_idx = f;
        stop_idx = e;
      end
      ACT_STEP: begin
        if (cur_idx >= stop_idx) begin
          cand_buf[0] = '{ch: '0, pos: '0, last: 1'b0, exh: 1'b1, idx: cur_idx};
          return 1;
        end
        rest = cur_idx;
        // least significant digit lands at the rightmost position
        for (k = 0; k < clen; k++) begin
          cand_buf[k] = '{ch: sym_tbl[SLOT_W'(rest % radix)], pos: POS_W'(clen - 1 - k),
                          last: (k == clen - 1), exh: 1'b0, idx: cur_idx};
          rest = rest / radix;
        end
        cur_idx = cur_idx + 1;
        return clen;
      end
      default: ;
    endcase
    return 0;
  endfunction

  function automatic int draw_gap();
    int r;
    if (tx_mode_left == 0) begin
      tx_calm = ($urandom_range(0, 3) == 0);
      tx_mode_left = $urandom_range(10, 40);
    end
    tx_mode_left--;
    if (tx_calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [IDX_W-1:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [IDX_W-1:0] pick_index();
    case ($urandom_range(0, 3))
      0: return 64'($urandom_range(0, 2000));
      1: return rnd64();
      2: return IDX_MAX - 64'($urandom_range(0, 8));
      default: return (64'd1 << $urandom_range(0, 63)) - 64'($urandom_range(0, 1));
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [IDX_W-1:0] got, logic [IDX_W-1:0] want);
    if (err_count < PRINT_CAP)
      $display("%0t: %s mismatch: got %0h, want %0h", $time, what, got, want);
    err_count++;
  endtask

  // offer one item, hold it until taken, then predict
  task automatic offer(action_t a, logic [SLOT_W-1:0] s, logic [SYM_W-1:0] v,
                       logic [IDX_W-1:0] f, logic [IDX_W-1:0] e,
                       logic typed, char_result_t res);
    int cnt;
    int gap;
    int k;
    in_valid_i <= 1'b1;
    action_i <= a;
    symbol_slot_i <= s;
    symbol_value_i <= v;
    range_first_i <= f;
    range_stop_i <= e;
    do @(posedge clk_i); while (in_stall_o);
    items_in++;
    cnt = enumerate_item(a, s, v, f, e);
    if (a == ACT_STEP) begin
      n_steps++;
      if (cand_buf[0].exh) n_exh++;
    end
    if (typed) due_chars.push_back(res);
    else for (k = 0; k < cnt; k++) due_chars.push_back(cand_buf[k]);
    gap = draw_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (due_chars.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic sel, logic [CFG_W-1:0] d);
    settle();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= sel;
    cfg_data_i <= d;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (sel == CFG_ALPHABET_SIZE) alpha_reg = d;
    else len_reg = d[LEN_W-1:0];
    n_writes++;
  endtask

  function automatic plan_row_t item_row(action_t a, logic [SLOT_W-1:0] s,
                                         logic [SYM_W-1:0] v, logic [IDX_W-1:0] f,
                                         logic [IDX_W-1:0] e);
    plan_row_t r;
    r = '{is_cfg: 1'b0, cfg_sel: 1'b0, cfg_val: '0, act: a, slot: s, sym: v,
          first: f, stop: e, typed: 1'b0, res: '0};
    return r;
  endfunction

  function automatic plan_row_t cfg_row(logic sel, logic [CFG_W-1:0] d);
    plan_row_t r;
    r = item_row(ACT_LOAD, '0, '0, '0, '0);
    r.is_cfg = 1'b1;
    r.cfg_sel = sel;
    r.cfg_val = d;
    return r;
  endfunction

  function automatic plan_row_t step_row(logic typed, logic [SYM_W-1:0] c, logic last,
                                         logic exh, logic [IDX_W-1:0] i);
    plan_row_t r;
    r = item_row(ACT_STEP, '0, '0, '0, '0);
    r.typed = typed;
    r.res = '{ch: c, pos: '0, last: last, exh: exh, idx: i};
    return r;
  endfunction

  task automatic run_phase(int ph);
    logic [CFG_W-1:0] a_cfg;
    logic [CFG_W-1:0] l_cfg;
    logic [IDX_W-1:0] f;
    logic [IDX_W-1:0] e;
    int steps;
    case (ph)
      0: begin a_cfg = 7'h7F; l_cfg = 7'h7F; end
      1: begin a_cfg = 7'd64; l_cfg = 7'd16; end
      2: begin a_cfg = 7'd1;  l_cfg = 7'd1;  end
      3: begin a_cfg = 7'd65; l_cfg = 7'd17; end
      default: begin
        a_cfg = CFG_W'($urandom_range(0, 127));
        l_cfg = ($urandom_range(0, 3) == 0) ? CFG_W'($urandom_range(0, 127))
                                             : CFG_W'($urandom_range(0, 5));
      end
    endcase
    write_reg(CFG_ALPHABET_SIZE, a_cfg);
    write_reg(CFG_CANDIDATE_LENGTH, l_cfg);
    repeat ($urandom_range(2, 5)) begin
      if ($urandom_range(0, 99) < 80) begin
        f = pick_index();
        steps = $urandom_range(0, 5);
        e = (f > IDX_MAX - 64'(steps)) ? IDX_MAX : f + 64'(steps);
        // empty or inverted range
        if ($urandom_range(0, 9) == 0) e = f - 64'($urandom_range(0, 3));
        offer(ACT_START, SLOT_W'($urandom), SYM_W'($urandom), f, e, 1'b0, '0);
        repeat (steps + 1) begin
          if ($urandom_range(0, 9) == 0)
            offer(ACT_LOAD, SLOT_W'($urandom), SYM_W'($urandom), rnd64(), rnd64(),
                  1'b0, '0);
          else if ($urandom_range(0, 19) == 0)
            offer(ACT_UNUSED, SLOT_W'($urandom), SYM_W'($urandom), rnd64(), rnd64(),
                  1'b0, '0);
          offer(ACT_STEP, SLOT_W'($urandom), SYM_W'($urandom), rnd64(), rnd64(),
                1'b0, '0);
        end
      end else begin
        repeat (3)
          offer(action_t'($urandom_range(0, 3)), SLOT_W'($urandom), SYM_W'($urandom),
                pick_index(), pick_index(), 1'b0, '0);
      end
    end
  endtask

  initial begin
    plan_row_t plan [$];
    plan_row_t row;
    int r;
    int ph;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    plan.push_back(step_row(1'b1, 8'h00, 1'b0, 1'b1, 64'd0));
    plan.push_back(item_row(ACT_LOAD, 6'd0, 8'hFF, '0, '0));
    plan.push_back(item_row(ACT_LOAD, 6'd63, 8'h00, IDX_MAX, IDX_MAX));
    plan.push_back(item_row(ACT_START, '0, '0, 64'd0, 64'd2));
    plan.push_back(step_row(1'b1, 8'hFF, 1'b1, 1'b0, 64'd0));
    plan.push_back(step_row(1'b1, 8'hFF, 1'b1, 1'b0, 64'd1));
    plan.push_back(step_row(1'b1, 8'h00, 1'b0, 1'b1, 64'd2));
    plan.push_back(item_row(ACT_UNUSED, 6'h3F, 8'hFF, IDX_MAX, IDX_MAX));
    plan.push_back(step_row(1'b1, 8'h00, 1'b0, 1'b1, 64'd2));
    plan.push_back(item_row(ACT_START, '0, '0, IDX_MAX - 1, IDX_MAX));
    plan.push_back(step_row(1'b1, 8'hFF, 1'b1, 1'b0, IDX_MAX - 1));
    plan.push_back(step_row(1'b1, 8'h00, 1'b0, 1'b1, IDX_MAX));
    plan.push_back(item_row(ACT_START, '0, '0, IDX_MAX, 64'd0));
    plan.push_back(step_row(1'b1, 8'h00, 1'b0, 1'b1, IDX_MAX));
    plan.push_back(cfg_row(CFG_ALPHABET_SIZE, 7'd0));
    plan.push_back(cfg_row(CFG_CANDIDATE_LENGTH, 7'h7F));
    plan.push_back(item_row(ACT_LOAD, 6'd1, 8'h5A, '0, '0));
    plan.push_back(item_row(ACT_START, '0, '0, 64'h8000_0000_0000_0001, IDX_MAX));
    plan.push_back(step_row(1'b0, '0, 1'b0, 1'b0, '0));
    plan.push_back(cfg_row(CFG_ALPHABET_SIZE, 7'd2));
    plan.push_back(cfg_row(CFG_CANDIDATE_LENGTH, 7'd0));
    plan.push_back(item_row(ACT_START, '0, '0, 64'd5, 64'd7));
    plan.push_back(step_row(1'b0, '0, 1'b0, 1'b0, '0));
    plan.push_back(step_row(1'b0, '0, 1'b0, 1'b0, '0));
    plan.push_back(cfg_row(CFG_CANDIDATE_LENGTH, 7'd16));
    plan.push_back(item_row(ACT_START, '0, '0, 64'hA5A5_A5A5_A5A5_A5A5, IDX_MAX));
    plan.push_back(step_row(1'b0, '0, 1'b0, 1'b0, '0));

    for (r = 0; r < plan.size(); r++) begin
      row = plan[r];
      if (row.is_cfg) write_reg(row.cfg_sel, row.cfg_val);
      else offer(row.act, row.slot, row.sym, row.first, row.stop, row.typed, row.res);
    end

    // fill the whole table before any radix above two is used
    for (r = 0; r < MAX_ALPHABET; r++)
      offer(ACT_LOAD, SLOT_W'(r), SYM_W'($urandom), rnd64(), rnd64(), 1'b0, '0);

    ph = 0;
    while (items_in < ITEM_TARGET) begin
      run_phase(ph);
      ph++;
    end

    settle();
    repeat (16) @(posedge clk_i);
    $display("run covered %0d items in %0d settings: %0d steps (%0d exhausted)",
             items_in, ph + 4, n_steps, n_exh);
    $display("%0d characters compared, %0d register writes, %0d mismatches",
             n_chars, n_writes, err_count);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // receiver: random stalls, one long hold-off to back the block up
  always @(posedge clk_i) begin : drive_stall
    int r;
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (!pressure_done && items_in >= 140) begin
      pressure_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_stall_i <= 1'b1;
    end else begin
      if (rx_mode_left == 0) begin
        rx_calm = ($urandom_range(0, 3) == 0);
        rx_mode_left = $urandom_range(20, 80);
      end
      rx_mode_left--;
      if (stall_left > 0) begin
        stall_left--;
      end else if (!rx_calm) begin
        r = $urandom_range(0, 99);
        if (r >= 93) stall_left = $urandom_range(10, 30);
        else if (r >= 65) stall_left = $urandom_range(1, 3);
      end
      out_stall_i <= (stall_left > 0);
    end
  end

  always @(posedge clk_i) begin : check_chars
    char_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_chars++;
      if (due_chars.size() == 0) begin
        report_mismatch("unexpected item, index", candidate_index_o, '0);
      end else begin
        want = due_chars.pop_front();
        if (char_out_o !== want.ch)
          report_mismatch("char_out", IDX_W'(char_out_o), IDX_W'(want.ch));
        if (char_position_o !== want.pos)
          report_mismatch("char_position", IDX_W'(char_position_o), IDX_W'(want.pos));
        if (last_char_o !== want.last)
          report_mismatch("last_char", IDX_W'(last_char_o), IDX_W'(want.last));
        if (exhausted_o !== want.exh)
          report_mismatch("exhausted", IDX_W'(exhausted_o), IDX_W'(want.exh));
        if (candidate_index_o !== want.idx)
          report_mismatch("candidate_index", candidate_index_o, want.idx);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("no handshake for %0d cycles, %0d items still due", quiet_cycles,
               due_chars.size());
      $display("TB_ERROR");
      $finish;
    end
  end

endmodule
